// ===== sv/ctc_pkg.sv =====
// Shared types, result codes and keyword/operator tables of the token classifier.
package ctc_pkg;

  typedef enum logic [2:0] {
    KIND_RESERVED = 3'd0,
    KIND_INTEGER  = 3'd1,
    KIND_FLOAT    = 3'd2,
    KIND_OPERATOR = 3'd3,
    KIND_VARIABLE = 3'd4,
    KIND_LINE     = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_t;

  // One queued event: first result kind, and whether a line break follows it.
  typedef struct packed {
    kind_t kind;
    logic  with_line;
  } ev_t;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned KW_COUNT = 16;
  localparam int unsigned OP_COUNT = 11;
  localparam logic [3:0]  LENGTH_CAP = 4'd9;
  localparam logic [1:0]  DOT_CAP    = 2'd2;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Strings right-aligned: first character in the highest used byte.
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    64'("const"),  64'("int"),    64'("float"),  64'("double"),
    64'("long"),   64'("static"), 64'("void"),   64'("char"),
    64'("extern"), 64'("return"), 64'("break"),  64'("enum"),
    64'("struct"), 64'("typedef"),64'("union"),  64'("goto")
  };
  localparam logic [3:0] KW_SIZE [KW_COUNT] = '{
    4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
  };

  localparam logic [15:0] OP_STR [OP_COUNT] = '{
    16'("+"),  16'("-"),  16'("*"),  16'("/"),  16'("="), 16'("=="),
    16'("!="), 16'(">="), 16'("<="), 16'(">"),  16'("<")
  };
  localparam logic [3:0] OP_SIZE [OP_COUNT] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1
  };

  // Does keyword idx hold byte c at position pos?
  function automatic logic kw_hit(input int unsigned idx, input logic [3:0] pos,
                                  input logic [7:0] c);
    logic [2:0] d;
    logic [5:0] sh;
    logic       hit;
    hit = 1'b0;
    d   = 3'd0;
    sh  = 6'd0;
    if (pos < KW_SIZE[idx]) begin
      d   = KW_SIZE[idx][2:0] - 3'd1 - pos[2:0];
      sh  = {d, 3'b000};
      hit = (KW_STR[idx][sh +: 8] == c);
    end
    return hit;
  endfunction

  function automatic logic op_hit(input int unsigned idx, input logic [3:0] pos,
                                  input logic [7:0] c);
    logic [1:0] d;
    logic [3:0] sh;
    logic       hit;
    hit = 1'b0;
    d   = 2'd0;
    sh  = 4'd0;
    if (pos < OP_SIZE[idx]) begin
      d   = OP_SIZE[idx][1:0] - 2'd1 - pos[1:0];
      sh  = {d[0], 3'b000};
      hit = (OP_STR[idx][sh +: 8] == c);
    end
    return hit;
  endfunction

endpackage

// ===== sv/ctc_front.sv =====
// Front end: takes text bytes, tracks the open token and emits events on delimiters.
module ctc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic [7:0]     in_ch,
  input  logic           in_end_of_text,
  input  logic           q_full,
  output logic           ev_push,
  output ctc_pkg::ev_t   ev
);

  logic [ctc_pkg::KW_COUNT-1:0] kw_alive_r, kw_alive_nxt;
  logic [ctc_pkg::OP_COUNT-1:0] op_alive_r, op_alive_nxt;
  logic [3:0]                   len_r, len_nxt;
  logic [1:0]                   dots_r, dots_nxt;
  logic                         num_ok_r, num_ok_nxt;
  logic                         id_ok_r, id_ok_nxt;
  logic                         halted_r, halted_nxt;

  logic                         acc, is_space, is_digit, is_letter, semi, delim;
  logic [ctc_pkg::KW_COUNT-1:0] kw_len_hit;
  logic [ctc_pkg::OP_COUNT-1:0] op_len_hit;
  ctc_pkg::kind_t               tok_kind;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  always_comb begin
    is_space  = (in_ch == 8'h20) || (in_ch >= 8'h09 && in_ch <= 8'h0D);
    is_digit  = (in_ch >= 8'h30 && in_ch <= 8'h39);
    is_letter = (in_ch >= 8'h61 && in_ch <= 8'h7A) || (in_ch >= 8'h41 && in_ch <= 8'h5A);
    semi      = !in_end_of_text && (in_ch == ctc_pkg::CH_SEMI);
    delim     = in_end_of_text || semi || is_space;
  end

  // Classify the token held in the registers (used when a delimiter arrives).
  always_comb begin
    for (int i = 0; i < ctc_pkg::KW_COUNT; i++) begin
      kw_len_hit[i] = kw_alive_r[i] && (ctc_pkg::KW_SIZE[i] == len_r);
    end
    for (int i = 0; i < ctc_pkg::OP_COUNT; i++) begin
      op_len_hit[i] = op_alive_r[i] && (ctc_pkg::OP_SIZE[i] == len_r);
    end
    priority if (|kw_len_hit)                  tok_kind = ctc_pkg::KIND_RESERVED;
    else if (|op_len_hit)                      tok_kind = ctc_pkg::KIND_OPERATOR;
    else if (num_ok_r && dots_r == 2'd0)       tok_kind = ctc_pkg::KIND_INTEGER;
    else if (num_ok_r && dots_r == 2'd1)       tok_kind = ctc_pkg::KIND_FLOAT;
    else if (id_ok_r)                          tok_kind = ctc_pkg::KIND_VARIABLE;
    else                                       tok_kind = ctc_pkg::KIND_ERROR;
  end

  always_comb begin
    kw_alive_nxt = kw_alive_r;
    op_alive_nxt = op_alive_r;
    len_nxt      = len_r;
    dots_nxt     = dots_r;
    num_ok_nxt   = num_ok_r;
    id_ok_nxt    = id_ok_r;
    halted_nxt   = halted_r;
    ev_push      = 1'b0;
    ev.kind      = tok_kind;
    ev.with_line = semi;

    if (acc && !halted_r) begin
      if (!delim) begin
        for (int i = 0; i < ctc_pkg::KW_COUNT; i++) begin
          kw_alive_nxt[i] = kw_alive_r[i] && ctc_pkg::kw_hit(i, len_r, in_ch);
        end
        for (int i = 0; i < ctc_pkg::OP_COUNT; i++) begin
          op_alive_nxt[i] = op_alive_r[i] && ctc_pkg::op_hit(i, len_r, in_ch);
        end
        if (!is_digit) begin
          if (in_ch == ctc_pkg::CH_DOT) begin
            if (dots_r < ctc_pkg::DOT_CAP) dots_nxt = dots_r + 2'd1;
          end else begin
            num_ok_nxt = 1'b0;
          end
        end
        if (len_r == 4'd0) begin
          if (!(is_letter || in_ch == ctc_pkg::CH_UNDER)) id_ok_nxt = 1'b0;
        end else begin
          if (!(is_letter || is_digit || in_ch == ctc_pkg::CH_UNDER)) id_ok_nxt = 1'b0;
        end
        if (len_r < ctc_pkg::LENGTH_CAP) len_nxt = len_r + 4'd1;
      end else begin
        kw_alive_nxt = '1;
        op_alive_nxt = '1;
        len_nxt      = 4'd0;
        dots_nxt     = 2'd0;
        num_ok_nxt   = 1'b1;
        id_ok_nxt    = 1'b1;
        if (len_r != 4'd0) begin
          ev_push = 1'b1;
          if (tok_kind == ctc_pkg::KIND_ERROR) begin
            halted_nxt   = 1'b1;
            ev.with_line = 1'b0;
          end
        end else if (semi) begin
          ev_push      = 1'b1;
          ev.kind      = ctc_pkg::KIND_LINE;
          ev.with_line = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_alive_r <= '1;
      op_alive_r <= '1;
      len_r      <= 4'd0;
      dots_r     <= 2'd0;
      num_ok_r   <= 1'b1;
      id_ok_r    <= 1'b1;
      halted_r   <= 1'b0;
    end else begin
      kw_alive_r <= kw_alive_nxt;
      op_alive_r <= op_alive_nxt;
      len_r      <= len_nxt;
      dots_r     <= dots_nxt;
      num_ok_r   <= num_ok_nxt;
      id_ok_r    <= id_ok_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

// ===== sv/ctc_queue.sv =====
// Small event queue between the front end and the result sequencer.
module ctc_queue #(
  parameter int unsigned DEPTH = ctc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ctc_pkg::ev_t push_ev,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output ctc_pkg::ev_t head_ev
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ctc_pkg::ev_t  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_ev    = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/ctc_back.sv =====
// Back end: turns each queued event into one or two result words.
module ctc_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  ctc_pkg::ev_t head_ev,
  output logic         q_pop,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [2:0]   out_kind,
  output logic         out_last
);

  // Set while the trailing line break of a two-word event is on show.
  logic second_r, second_nxt;
  logic take;

  assign out_empty = !head_valid;
  assign take      = out_pop && head_valid;
  assign out_kind  = second_r ? 3'(ctc_pkg::KIND_LINE) : 3'(head_ev.kind);
  assign out_last  = second_r || !head_ev.with_line;

  always_comb begin
    second_nxt = second_r;
    q_pop      = 1'b0;
    if (take) begin
      if (head_ev.with_line && !second_r) begin
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        q_pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

endmodule

// ===== sv/c_token_classifier_unit.sv =====
// Top level of the token classifier: front end, event queue and result sequencer.
// Text bytes go in one word per cycle through in_push/in_full; a byte is taken
// every cycle as long as the event queue has room. Whitespace (space, tab, LF,
// VT, FF, CR), ';' or an end-of-text word closes the open token, which is then
// classified as reserved, operator, integer, float or variable, in that order
// of precedence, or flagged as a compile error. A ';' adds a line-break word
// after the token it closes. A compile error is the last word given: all later
// input is taken and dropped until reset. Results come out of out_kind/out_last
// through out_empty/out_pop; out_last marks the final word caused by one input.
// The event of the closing byte is registered in the queue before its first
// result shows. The queue holds QUEUE_DEPTH events; a token closed by ';' yields
// two result words from one event, so input stalls only if the consumer falls
// behind for long enough to fill the queue.
module c_token_classifier_unit #(
  parameter int unsigned QUEUE_DEPTH = ctc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte stream in
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_text,
  // result words out
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_kind,
  output logic       out_last
);

  logic         q_full, ev_push, q_pop, head_valid;
  ctc_pkg::ev_t ev, head_ev;

  // front end: token tracking and classification
  ctc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ch          (in_ch),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .ev_push        (ev_push),
    .ev             (ev)
  );

  // decouples the front end from the consumer's pace
  ctc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_push),
    .push_ev    (ev),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_ev    (head_ev)
  );

  // back end: one or two result words per event
  ctc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ev    (head_ev),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

endmodule
